// ===== rtl/pbdec_pkg.sv =====
// Shared types and constants of the PackBits channel-plane decoder.
`timescale 1ns / 1ps
`default_nettype none

package pbdec_pkg;

  // Configuration port geometry.
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Default limits of the top-level parameters.
  localparam int DefaultMaxDim    = 8192;
  localparam int DefaultMaxStride = 4;

  // Depth of the request queue between the front and the back part.
  localparam int CmdDepth = 4;

  // Reset values of the configuration registers.
  localparam logic [13:0] LineWidthRst  = 14'd1;
  localparam logic [13:0] LineCountRst  = 14'd1;
  localparam logic [2:0]  StrideRst     = 3'd1;
  localparam logic [1:0]  OffsetRst     = 2'd0;
  localparam logic        ModeRst       = 1'b1;

  // Encoding modes.
  localparam logic ModeRaw = 1'b0;
  localparam logic ModeRle = 1'b1;

  typedef struct packed {
    logic [13:0] line_width;
    logic [13:0] line_count;
    logic [2:0]  pixel_stride;
    logic [1:0]  channel_offset;
    logic        encoding_mode;
  } cfg_t;

  // One write request: count pixels of one byte value starting at addr.
  typedef struct packed {
    logic [27:0] addr;
    logic [7:0]  data;
    logic [7:0]  count;
    logic        ovr;
    logic        done;
  } cmd_t;

  typedef struct packed {
    logic [27:0] byte_address;
    logic [7:0]  data0;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  data3;
    logic [2:0]  byte_count;
    logic        run_last;
    logic        channel_done;
    logic        overrun_error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/pbdec_regs.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module pbdec_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel_i,
  input  wire logic                       penable_i,
  input  wire logic                       pwrite_i,
  input  wire logic [pbdec_pkg::AddrW-1:0] paddr_i,
  input  wire logic [pbdec_pkg::DataW-1:0] pwdata_i,
  output logic      [pbdec_pkg::DataW-1:0] prdata_o,
  output logic                            pready_o,
  output pbdec_pkg::cfg_t                 cfg_o
);
  import pbdec_pkg::*;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH     = 3'd0,
    REG_LINE_COUNT     = 3'd1,
    REG_PIXEL_STRIDE   = 3'd2,
    REG_CHANNEL_OFFSET = 3'd3,
    REG_ENCODING_MODE  = 3'd4
  } reg_idx_e;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx      = reg_idx_e'(paddr_i[4:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LINE_WIDTH:     cfg_d.line_width     = pwdata_i[13:0];
        REG_LINE_COUNT:     cfg_d.line_count     = pwdata_i[13:0];
        REG_PIXEL_STRIDE:   cfg_d.pixel_stride   = pwdata_i[2:0];
        REG_CHANNEL_OFFSET: cfg_d.channel_offset = pwdata_i[1:0];
        REG_ENCODING_MODE:  cfg_d.encoding_mode  = pwdata_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_WIDTH:     prdata_o = DataW'(cfg_q.line_width);
      REG_LINE_COUNT:     prdata_o = DataW'(cfg_q.line_count);
      REG_PIXEL_STRIDE:   prdata_o = DataW'(cfg_q.pixel_stride);
      REG_CHANNEL_OFFSET: prdata_o = DataW'(cfg_q.channel_offset);
      REG_ENCODING_MODE:  prdata_o = DataW'(cfg_q.encoding_mode);
      default:            prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width     <= LineWidthRst;
      cfg_q.line_count     <= LineCountRst;
      cfg_q.pixel_stride   <= StrideRst;
      cfg_q.channel_offset <= OffsetRst;
      cfg_q.encoding_mode  <= ModeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbdec_front.sv =====
// Front part: classifies stream bytes, tracks the write position, issues requests.
`timescale 1ns / 1ps
`default_nettype none

module pbdec_front #(
  parameter int MAX_DIMENSION = pbdec_pkg::DefaultMaxDim
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  pbdec_pkg::cfg_t      cfg_i,
  input  wire logic [2:0]      stride_i,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  output logic                 cmd_valid_o,
  output pbdec_pkg::cmd_t      cmd_o
);
  import pbdec_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int SW = (DW > 8) ? DW : 8;

  typedef enum logic [3:0] {
    PH_TABLE = 4'b0001,
    PH_CTRL  = 4'b0010,
    PH_LIT   = 4'b0100,
    PH_REP   = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [DW:0] tbl_q, tbl_d;
  logic [7:0]  rbl_q, rbl_d;
  logic [6:0]  disc_q, disc_d;
  logic [DW-1:0] col_q, col_d, row_q, row_d;
  logic [27:0] pa_q, pa_d;

  logic [DW-1:0] w_eff, h_eff, rem;
  logic        rle;
  logic        is_lit, is_drop, is_raw, is_tab, is_ctrl, is_rep, rest;
  logic [7:0]  n_lit, lit_take, n_rep, rep_take, adv_n;
  logic        rep_ovr, do_adv, line_end, last_row, done;
  logic [SW:0] col_sum;
  logic [DW:0] row_inc, tbl_dec;
  logic [10:0] step;
  logic [27:0] pa_adv;

  // Effective dimensions: zero acts as one, large values saturate.
  always_comb begin
    if (cfg_i.line_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(cfg_i.line_width) > 32'(MAX_DIMENSION)) begin
      w_eff = DW'(MAX_DIMENSION);
    end else begin
      w_eff = DW'(cfg_i.line_width);
    end
    if (cfg_i.line_count == '0) begin
      h_eff = DW'(1);
    end else if (32'(cfg_i.line_count) > 32'(MAX_DIMENSION)) begin
      h_eff = DW'(MAX_DIMENSION);
    end else begin
      h_eff = DW'(cfg_i.line_count);
    end
  end

  // A column left beyond a shrunk line still gets one pixel.
  assign rem = (col_q < w_eff) ? (w_eff - col_q) : DW'(1);

  assign rle     = (cfg_i.encoding_mode == ModeRle);
  assign is_lit  = rle && (phase_q == PH_LIT);
  assign is_drop = !is_lit && (disc_q != '0);
  assign is_raw  = !is_lit && !is_drop && !rle;
  assign rest    = !is_lit && !is_drop && rle;
  assign is_tab  = rest && (phase_q == PH_TABLE);
  assign is_ctrl = rest && (phase_q == PH_CTRL);
  assign is_rep  = rest && (phase_q == PH_REP);

  assign n_lit    = {1'b0, data_byte_i[6:0]} + 8'd1;
  assign lit_take = (SW'(n_lit) < SW'(rem)) ? n_lit : 8'(rem);
  assign n_rep    = (rbl_q != '0) ? rbl_q : 8'd1;
  assign rep_take = (SW'(n_rep) < SW'(rem)) ? n_rep : 8'(rem);
  assign rep_ovr  = (n_rep > rep_take);

  assign adv_n  = (is_lit || is_raw) ? 8'd1 : (is_rep ? rep_take : 8'd0);
  assign do_adv = accept_i && (is_lit || is_raw || is_rep);

  // Position update for a run of adv_n pixels; a run never crosses a line end.
  assign step     = 11'(adv_n) * 11'(stride_i);
  assign pa_adv   = pa_q + 28'(step);
  assign col_sum  = (SW + 1)'(col_q) + (SW + 1)'(adv_n);
  assign line_end = (col_sum >= (SW + 1)'(w_eff));
  assign row_inc  = (DW + 1)'(row_q) + (DW + 1)'(1);
  assign last_row = (row_inc >= (DW + 1)'(h_eff));
  assign done     = do_adv && line_end && last_row;
  assign tbl_dec  = tbl_q - (DW + 1)'(1);

  always_comb begin
    cmd_valid_o = do_adv;
    cmd_o.addr  = pa_q + 28'(cfg_i.channel_offset);
    cmd_o.data  = data_byte_i;
    cmd_o.count = adv_n;
    cmd_o.ovr   = is_lit ? ((rbl_q <= 8'd1) && (disc_q != '0)) : (is_rep && rep_ovr);
    cmd_o.done  = done;
  end

  always_comb begin
    phase_d = phase_q;
    tbl_d   = tbl_q;
    rbl_d   = rbl_q;
    disc_d  = disc_q;
    col_d   = col_q;
    row_d   = row_q;
    pa_d    = pa_q;
    if (accept_i) begin
      if (do_adv) begin
        pa_d = pa_adv;
        if (line_end) begin
          col_d = '0;
          row_d = DW'(row_inc);
        end else begin
          col_d = DW'(col_sum);
        end
      end
      if (is_lit) begin
        rbl_d = (rbl_q != '0) ? (rbl_q - 8'd1) : 8'd0;
        if (rbl_d == '0) begin
          phase_d = PH_CTRL;
        end
      end
      if (is_drop) begin
        disc_d = disc_q - 7'd1;
      end
      if (is_tab) begin
        tbl_d = (tbl_q == '0) ? ({h_eff, 1'b0} - (DW + 1)'(1)) : tbl_dec;
        if (tbl_d == '0) begin
          phase_d = PH_CTRL;
        end
      end
      if (is_ctrl) begin
        if (!data_byte_i[7]) begin
          rbl_d   = lit_take;
          disc_d  = 7'(n_lit - lit_take);
          phase_d = PH_LIT;
        end else if (data_byte_i != 8'h80) begin
          rbl_d   = 8'(9'd257 - {1'b0, data_byte_i});
          phase_d = PH_REP;
        end
      end
      if (is_rep) begin
        rbl_d   = '0;
        phase_d = PH_CTRL;
      end
      // The end of the plane rearms the decoder for the next one.
      if (done) begin
        phase_d = PH_TABLE;
        tbl_d   = '0;
        rbl_d   = '0;
        col_d   = '0;
        row_d   = '0;
        pa_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TABLE;
      tbl_q   <= '0;
      rbl_q   <= '0;
      disc_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pa_q    <= '0;
    end else begin
      phase_q <= phase_d;
      tbl_q   <= tbl_d;
      rbl_q   <= rbl_d;
      disc_q  <= disc_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pa_q    <= pa_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbdec_fifo.sv =====
// Short request queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module pbdec_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  pbdec_pkg::cmd_t wdata_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output pbdec_pkg::cmd_t rdata_o
);
  import pbdec_pkg::*;

  localparam int PtrW = $clog2(CmdDepth);
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbdec_back.sv =====
// Back part: splits each request into results of up to four bytes.
`timescale 1ns / 1ps
`default_nettype none

module pbdec_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [2:0] stride_i,
  input  wire logic       cmd_valid_i,
  input  pbdec_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  wire logic       pop_i,
  output logic            out_valid_o,
  output pbdec_pkg::res_t res_o
);
  import pbdec_pkg::*;

  logic        act_q, out_valid_q;
  logic [27:0] addr_q;
  logic [7:0]  left_q, byte_q;
  logic        ovr_q, done_q;
  res_t        res_q, res_d;
  logic        chunk_last, out_load;
  logic [2:0]  cnt;

  assign chunk_last = (left_q <= 8'd4);
  assign cnt        = chunk_last ? left_q[2:0] : 3'd4;
  assign out_load   = act_q && (!out_valid_q || pop_i);
  assign cmd_pop_o  = cmd_valid_i && (!act_q || (out_load && chunk_last));

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    res_d.byte_address  = addr_q;
    res_d.data0         = byte_q;
    res_d.data1         = (cnt > 3'd1) ? byte_q : 8'd0;
    res_d.data2         = (cnt > 3'd2) ? byte_q : 8'd0;
    res_d.data3         = (cnt > 3'd3) ? byte_q : 8'd0;
    res_d.byte_count    = cnt;
    res_d.run_last      = chunk_last;
    res_d.channel_done  = done_q && chunk_last;
    res_d.overrun_error = ovr_q && chunk_last;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
    if (cmd_pop_o) begin
      addr_q <= cmd_i.addr;
      left_q <= cmd_i.count;
      byte_q <= cmd_i.data;
      ovr_q  <= cmd_i.ovr;
      done_q <= cmd_i.done;
    end else if (out_load) begin
      addr_q <= addr_q + 28'({stride_i, 2'b00});
      left_q <= left_q - 8'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        act_q <= 1'b1;
      end else if (out_load && chunk_last) begin
        act_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/packbits_channel_plane_decoder.sv =====
// Top level of the PackBits channel-plane decoder.
`timescale 1ns / 1ps
`default_nettype none

// The decoder fills one channel plane of an interleaved 8-bit image from a
// byte stream that is pushed in one byte per request. In RLE mode it first
// skips the scanline length table (two bytes per scanline) and then decodes
// PackBits: a control byte of 0 to 127 starts a literal run of n+1 bytes, a
// control byte of -127 to -1 repeats the next byte 1-n times, and -128 is
// ignored. In raw mode every byte is one pixel. Each result request carries
// up to four pixel bytes of the same value run and the interleaved byte
// address of the first one (pixel index times stride plus channel offset);
// further bytes sit one stride apart. Runs that would pass the end of a
// scanline are clipped there, and the last result of such a run carries
// overrun_error; the surplus literal bytes are consumed without results.
// The result that writes the last pixel of the plane carries channel_done,
// and the decoder then expects a new length table. The front part classifies
// each byte and updates the write position in the cycle it is accepted, so
// input bytes are taken at one per cycle. A repeat run of n pixels leaves the
// back part as ceil(n/4) results at one per cycle while results are popped;
// literal and raw bytes give one result each. A four-entry queue between
// the parts lets the front take bytes while a long repeat drains; input
// stalls (full high) only when it fills. A request passes the queue, then
// the back part's run and result registers. The user must write configuration
// over the APB-style port only while the decoder is idle; it is not enforced.
module packbits_channel_plane_decoder #(
  parameter int MAX_DIMENSION = pbdec_pkg::DefaultMaxDim,
  parameter int MAX_STRIDE    = pbdec_pkg::DefaultMaxStride
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pbdec_pkg::AddrW-1:0] paddr,
  input  wire logic [pbdec_pkg::DataW-1:0] pwdata,
  output logic      [pbdec_pkg::DataW-1:0] prdata,
  output logic                             pready,
  // Input byte stream.
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  data_byte_i,
  // Result stream.
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [27:0]                 byte_address_o,
  output logic      [7:0]                  data0_o,
  output logic      [7:0]                  data1_o,
  output logic      [7:0]                  data2_o,
  output logic      [7:0]                  data3_o,
  output logic      [2:0]                  byte_count_o,
  output logic                             run_last_o,
  output logic                             channel_done_o,
  output logic                             overrun_error_o
);
  import pbdec_pkg::*;

  cfg_t       cfg;
  logic [2:0] stride_eff;
  logic       in_accept, out_pop;
  logic       cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t       cmd_front, cmd_back;
  logic       out_valid;
  res_t       res;

  pbdec_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // A stride of zero acts as one; strides above the limit saturate.
  always_comb begin
    if (cfg.pixel_stride == '0) begin
      stride_eff = 3'd1;
    end else if (32'(cfg.pixel_stride) > 32'(MAX_STRIDE)) begin
      stride_eff = 3'(MAX_STRIDE);
    end else begin
      stride_eff = cfg.pixel_stride;
    end
  end

  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  pbdec_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stride_i    (stride_eff),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_front)
  );

  pbdec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_front),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_back)
  );

  assign out_pop = pop && out_valid;

  pbdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stride_i    (stride_eff),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_back),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (out_pop),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign empty           = !out_valid;
  assign byte_address_o  = res.byte_address;
  assign data0_o         = res.data0;
  assign data1_o         = res.data1;
  assign data2_o         = res.data2;
  assign data3_o         = res.data3;
  assign byte_count_o    = res.byte_count;
  assign run_last_o      = res.run_last;
  assign channel_done_o  = res.channel_done;
  assign overrun_error_o = res.overrun_error;

  // The front only issues a request for a byte it has accepted, which
  // requires room in the queue.
  a_no_push_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_push |-> (in_accept && !cmd_full))
    else $error("request issued while the queue is full");

  // Every request writes at least one pixel.
  a_cmd_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_push |-> (cmd_front.count != 8'd0))
    else $error("empty write request");

  // Plane end and clipping are flagged only on the last result of a run.
  a_flags_on_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (channel_done_o || overrun_error_o)) |-> run_last_o)
    else $error("status flag on a result that is not the last of its run");

  // A shown result holds one to four bytes.
  a_byte_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((byte_count_o != 3'd0) && (byte_count_o <= 3'd4)))
    else $error("byte count out of range");

endmodule

`default_nettype wire
